>>> rtl/sqde_pkg.sv
// Package for the circular deque engine: ring size, command and status codes,
// and the packed payload types of the command and result channels.
// No dependencies; used by the core and by its checker.
`default_nettype none

package sqde_pkg;

    // Ring geometry. The index wraps by truncation, so the depth is a power of two.
    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int DATA_W     = 32;

    typedef logic [2:0]                cmd_t;
    typedef logic [1:0]                status_t;
    typedef logic signed [DATA_W-1:0]  value_t;

    // Command codes.
    localparam cmd_t CMD_PUSH = 3'd0;
    localparam cmd_t CMD_POP  = 3'd1;
    localparam cmd_t CMD_SWAP = 3'd2;
    localparam cmd_t CMD_ROTL = 3'd3;
    localparam cmd_t CMD_ROTR = 3'd4;

    // Status codes.
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_POP_EMPTY  = 2'd1;
    localparam status_t ST_SWAP_SHORT = 2'd2;
    localparam status_t ST_PUSH_FULL  = 2'd3;

    // Command word.
    typedef struct packed {
        cmd_t   cmd;
        value_t push_value;
    } sqde_in_t;

    // Result word.
    typedef struct packed {
        status_t    status;
        value_t     top_value;
        logic       top_valid;
        logic [6:0] depth;
    } sqde_out_t;

endpackage

`default_nettype wire

>>> rtl/stack_queue_deque_engine_core.sv
// Circular deque engine core: ring memory, top caches and command datapath.
// Depends on sqde_pkg for types, codes and the ring size.
//
// The engine takes one command word per clock while the result side does not
// stall, and returns one result word per command through the input register
// and then the result register. The two entries nearest the top are held in
// registers, and the ring memory holds the rest; every cycle the memory's two
// read ports fetch the entry two below the top and the bottom entry for the
// state that the current command leaves, so the following command finds both
// ready. Since each command writes at most one ring slot and needs only these
// prefetched entries, the sustained rate is one command per clock whenever the
// result side does not stall. The ring needs no clearing after reset; the
// config register queue_mode may be written at any time the engine is idle.
`default_nettype none

module stack_queue_deque_engine_core
    import sqde_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    // Command channel.
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire sqde_in_t  in_data,
    // Result channel.
    output logic           out_valid,
    input  wire logic      out_stall,
    output sqde_out_t      out_data,
    // Configuration write channel.
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    // Input stage.
    logic           in_valid_reg;
    sqde_in_t       in_data_reg;
    logic           accept;
    logic           fire;

    // Result stage.
    logic           out_valid_reg;
    sqde_out_t      out_data_reg;

    // Configuration.
    logic           queue_mode_reg;

    // Ring state and top caches.
    logic [IDX_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] count_reg, count_next;
    value_t           t0_reg, t0_next;
    value_t           t1_reg, t1_next;
    status_t          status;

    // Memory ports.
    value_t           mem [RING_DEPTH];
    logic             we;
    logic [IDX_W-1:0] waddr;
    value_t           wdata;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    value_t           rd_a_reg;
    value_t           rd_b_reg;
    value_t           wr_data_reg;
    logic             byp_a_reg;
    logic             byp_b_reg;
    value_t           below_val;
    value_t           bottom_val;

    // Handshake: the input register advances when the result register can load.
    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // Prefetched entries with forwarding of a same-cycle write.
    assign below_val  = byp_a_reg ? wr_data_reg : rd_a_reg;
    assign bottom_val = byp_b_reg ? wr_data_reg : rd_b_reg;

    // Command datapath: next ring state, cache contents and the one slot write.
    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        we         = 1'b0;
        waddr      = top_reg + IDX_W'(1);
        wdata      = t1_reg;
        status     = ST_OK;
        if (fire)
        begin
            unique case (in_data_reg.cmd)
                CMD_PUSH:
                begin
                    if (count_reg == CNT_W'(RING_DEPTH))
                    begin
                        status = ST_PUSH_FULL;
                    end
                    else if (!queue_mode_reg)
                    begin
                        // The old second entry moves into the memory region.
                        count_next = count_reg + CNT_W'(1);
                        top_next   = top_reg - IDX_W'(1);
                        t0_next    = in_data_reg.push_value;
                        t1_next    = t0_reg;
                        we         = (count_reg >= CNT_W'(2));
                        waddr      = top_reg + IDX_W'(1);
                        wdata      = t1_reg;
                    end
                    else
                    begin
                        // Append below the current bottom.
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(0))
                        begin
                            t0_next = in_data_reg.push_value;
                        end
                        if (count_reg == CNT_W'(1))
                        begin
                            t1_next = in_data_reg.push_value;
                        end
                        we    = (count_reg >= CNT_W'(2));
                        waddr = top_reg + count_reg[IDX_W-1:0];
                        wdata = in_data_reg.push_value;
                    end
                end
                CMD_POP:
                begin
                    if (count_reg == CNT_W'(0))
                    begin
                        status = ST_POP_EMPTY;
                    end
                    else
                    begin
                        top_next   = top_reg + IDX_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        t0_next    = t1_reg;
                        t1_next    = below_val;
                    end
                end
                CMD_SWAP:
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        status = ST_SWAP_SHORT;
                    end
                    else
                    begin
                        t0_next = t1_reg;
                        t1_next = t0_reg;
                    end
                end
                CMD_ROTL:
                begin
                    if (count_reg >= CNT_W'(2))
                    begin
                        // The top goes to the slot below the bottom.
                        top_next = top_reg + IDX_W'(1);
                        t0_next  = t1_reg;
                        t1_next  = (count_reg == CNT_W'(2)) ? t0_reg : below_val;
                        we       = (count_reg >= CNT_W'(3));
                        waddr    = top_reg + count_reg[IDX_W-1:0];
                        wdata    = t0_reg;
                    end
                end
                CMD_ROTR:
                begin
                    if (count_reg >= CNT_W'(2))
                    begin
                        // The bottom comes up above the top.
                        top_next = top_reg - IDX_W'(1);
                        t0_next  = (count_reg == CNT_W'(2)) ? t1_reg : bottom_val;
                        t1_next  = t0_reg;
                        we       = (count_reg >= CNT_W'(3));
                        waddr    = top_reg + IDX_W'(1);
                        wdata    = t1_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Prefetch addresses for the state that this cycle leaves.
    assign rd_addr_a = top_next + IDX_W'(2);
    assign rd_addr_b = top_next + count_next[IDX_W-1:0] - IDX_W'(1);

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg    <= mem[rd_addr_a];
        rd_b_reg    <= mem[rd_addr_b];
        wr_data_reg <= wdata;
    end

    // Forwarding flags for a read that meets the write of the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end
        else
        begin
            byp_a_reg <= we && (waddr == rd_addr_a);
            byp_b_reg <= we && (waddr == rd_addr_b);
        end
    end

    // Control state: handshake, configuration and ring pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            queue_mode_reg <= 1'b0;
            top_reg        <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= fire || (out_valid_reg && out_stall);
            if (cfg_valid && cfg_ready)
            begin
                queue_mode_reg <= cfg_data;
            end
            top_reg   <= top_next;
            count_reg <= count_next;
        end
    end

    // Payload registers: command word, top caches and result word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
        t0_reg <= t0_next;
        t1_reg <= t1_next;
        if (fire)
        begin
            out_data_reg.status    <= status;
            out_data_reg.top_value <= (count_next != CNT_W'(0)) ? t0_next : '0;
            out_data_reg.top_valid <= (count_next != CNT_W'(0));
            out_data_reg.depth     <= 7'(count_next);
        end
    end

endmodule

`default_nettype wire

>>> rtl/sqde_checker.sv
// Port-level checker for the circular deque engine core, with its bind.
// Depends on sqde_pkg and on the port list of stack_queue_deque_engine_core.
`default_nettype none

module sqde_checker
    import sqde_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire sqde_out_t out_data
);

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // The valid flag and the zeroed top follow the reported depth.
    a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.top_valid == (out_data.depth != 7'd0)) &&
                      (out_data.top_valid || out_data.top_value == '0))
        else $error("top_valid or top_value disagrees with depth");

    // The depth never exceeds the ring size.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.depth <= 7'(RING_DEPTH))
        else $error("depth beyond ring size");

    // A failed pop is reported only on an empty ring.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_POP_EMPTY |-> out_data.depth == 7'd0)
        else $error("pop-empty status with entries held");

    // A refused push is reported only on a full ring.
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_PUSH_FULL |-> out_data.depth == 7'(RING_DEPTH))
        else $error("push-full status on a ring that is not full");

endmodule

bind stack_queue_deque_engine_core sqde_checker u_sqde_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
